### hdl/ffsa_pkg.sv
`default_nettype none
package ffsa_pkg;

  localparam int REQ_W    = 1;
  localparam int SIZE_W   = 15;
  localparam int OFFSET_W = 14;
  localparam int STATUS_W = 2;
  localparam int MARK_W   = 2;

  // Run length in bytes stays below the largest size plus one segment.
  localparam int RUN_W    = 17;

  typedef enum logic [MARK_W-1:0] {
    MARK_FREE = 2'd0,
    MARK_HEAD = 2'd1,
    MARK_CONT = 2'd2
  } mark_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_INVALID = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    IDX_HOLD = 3'd0,
    IDX_ZERO = 3'd1,
    IDX_INC  = 3'd2,
    IDX_SEG  = 3'd3,
    IDX_HEAD = 3'd4
  } idx_op_t;

  typedef struct packed {
    logic    ld_req;
    idx_op_t idx_op;
    logic    wr_en;
    mark_t   wr_mark;
    logic    scan_en;
    logic    div_step;
    logic    finish;
    stat_t   fin_status;
    logic    fin_alloc;
  } cmd_t;

  typedef struct packed {
    logic req_free;
    logic size_zero;
    logic run_found;
    logic idx_last;
    logic idx_top;
    logic mark_head;
    logic mark_cont;
    logic seg_oob;
    logic at_head;
    logic at_end;
  } sts_t;

endpackage
`default_nettype wire

### hdl/ffsa_ram.sv
`default_nettype none
module ffsa_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### hdl/ffsa_ctrl.sv
`default_nettype none
module ffsa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire ffsa_pkg::sts_t sts,
  output ffsa_pkg::cmd_t     cmd
);
  import ffsa_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DISP  = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_MARK  = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_FLOAD = 9'b001000000,
    S_FHEAD = 9'b010000000,
    S_WALK  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_mark = MARK_FREE;
        cmd.idx_op  = IDX_INC;
        if (sts.idx_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.ld_req = 1'b1;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.req_free) begin
          state_nxt = S_DIV;
        end else if (sts.size_zero) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_INVALID;
          state_nxt      = S_IDLE;
        end else begin
          cmd.idx_op = IDX_ZERO;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.run_found) begin
          cmd.idx_op = IDX_HEAD;
          state_nxt  = S_MARK;
        end else if (sts.idx_last) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_NOFIT;
          state_nxt      = S_IDLE;
        end else begin
          cmd.idx_op = IDX_INC;
        end
      end
      S_MARK: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_mark = sts.at_head ? MARK_HEAD : MARK_CONT;
        if (sts.at_end) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_OK;
          cmd.fin_alloc  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.idx_op = IDX_INC;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = S_FLOAD;
      end
      S_FLOAD: begin
        if (sts.seg_oob) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_INVALID;
          state_nxt      = S_IDLE;
        end else begin
          cmd.idx_op = IDX_SEG;
          state_nxt  = S_FHEAD;
        end
      end
      S_FHEAD: begin
        if (sts.mark_head) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_mark = MARK_FREE;
          cmd.idx_op  = IDX_INC;
          state_nxt   = S_WALK;
        end else begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_INVALID;
          state_nxt      = S_IDLE;
        end
      end
      S_WALK: begin
        if (sts.idx_top || !sts.mark_cont) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_OK;
          state_nxt      = S_IDLE;
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.wr_mark = MARK_FREE;
          cmd.idx_op  = IDX_INC;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### hdl/ffsa_dp.sv
`default_nettype none
module ffsa_dp #(
  parameter int SEGMENTS  = 2048,
  parameter int SEG_BYTES = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire ffsa_pkg::cmd_t                  cmd,
  output ffsa_pkg::sts_t                       sts,
  input  wire logic                            in_req_type,
  input  wire logic [ffsa_pkg::SIZE_W-1:0]     in_size_bytes,
  input  wire logic [ffsa_pkg::OFFSET_W-1:0]   in_free_offset,
  output logic                                 out_valid,
  output logic      [ffsa_pkg::STATUS_W-1:0]   out_status,
  output logic      [ffsa_pkg::OFFSET_W-1:0]   out_alloc_offset
);
  import ffsa_pkg::*;

  localparam int IW  = $clog2(SEGMENTS);
  localparam int CW  = $clog2(SEGMENTS + 1);
  localparam int SBW = $clog2(SEG_BYTES + 1);
  localparam int PW  = IW + SBW;

  // Offset to segment by reciprocal multiply, exact for every offset value.
  localparam int DIV_SH = OFFSET_W + $clog2(SEG_BYTES);
  localparam int RCP    = ((1 << DIV_SH) + SEG_BYTES - 1) / SEG_BYTES;
  localparam int PRD_W  = 2 * OFFSET_W + 2;

  logic                req_type_r;
  logic [SIZE_W-1:0]   size_r;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [IW-1:0]       head_r, end_r, head_sel;
  logic [RUN_W-1:0]    run_r, run_sum;
  logic [OFFSET_W-1:0] quot_r, seg_quot;
  logic [PRD_W-1:0]    seg_prod;
  logic [MARK_W-1:0]   rd_data;
  logic                mark_free;
  logic [PW-1:0]       head_bytes;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [OFFSET_W-1:0] out_offset_r;

  ffsa_ram #(
    .WIDTH (MARK_W),
    .DEPTH (SEGMENTS)
  ) u_mark_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (idx_r[IW-1:0]),
    .wr_data (cmd.wr_mark),
    .rd_addr (idx_nxt[IW-1:0]),
    .rd_data (rd_data)
  );

  // Read address follows the next index, so rd_data always holds mark[idx_r].
  always_comb begin
    case (cmd.idx_op)
      IDX_ZERO: idx_nxt = '0;
      IDX_INC:  idx_nxt = idx_r + CW'(1);
      IDX_SEG:  idx_nxt = CW'(quot_r);
      IDX_HEAD: idx_nxt = CW'(head_sel);
      default:  idx_nxt = idx_r;
    endcase
  end

  assign mark_free = (rd_data == MARK_FREE);
  assign run_sum   = run_r + RUN_W'(SEG_BYTES);
  assign head_sel  = (run_r == '0) ? idx_r[IW-1:0] : head_r;

  assign seg_prod = PRD_W'(quot_r) * PRD_W'(RCP);
  assign seg_quot = OFFSET_W'(seg_prod >> DIV_SH);

  assign head_bytes = PW'(head_r) * PW'(SEG_BYTES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      req_type_r <= in_req_type;
      size_r     <= in_size_bytes;
      run_r      <= '0;
      quot_r     <= in_free_offset;
    end
    if (cmd.scan_en) begin
      if (mark_free) begin
        head_r <= head_sel;
        run_r  <= run_sum;
        end_r  <= idx_r[IW-1:0];
      end else begin
        run_r <= '0;
      end
    end
    // Replace the held offset by its segment index.
    if (cmd.div_step) begin
      quot_r <= seg_quot;
    end
    if (cmd.finish) begin
      out_status_r <= cmd.fin_status;
      out_offset_r <= cmd.fin_alloc ? OFFSET_W'(head_bytes) : '0;
    end
  end

  always_comb begin
    sts.req_free  = req_type_r;
    sts.size_zero = (size_r == '0);
    sts.run_found = mark_free && (run_sum >= RUN_W'(size_r));
    sts.idx_last  = (idx_r == CW'(SEGMENTS - 1));
    sts.idx_top   = (idx_r == CW'(SEGMENTS));
    sts.mark_head = (rd_data == MARK_HEAD);
    sts.mark_cont = (rd_data == MARK_CONT);
    sts.seg_oob   = (RUN_W'(quot_r) >= RUN_W'(SEGMENTS));
    sts.at_head   = (idx_r[IW-1:0] == head_r);
    sts.at_end    = (idx_r[IW-1:0] == end_r);
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_alloc_offset = out_offset_r;

endmodule
`default_nettype wire

### hdl/first_fit_segment_allocator.sv
`default_nettype none
// First-fit segment allocator for a pool of SEGMENTS segments of SEG_BYTES bytes.
// Request channel: drive in_req_type, in_size_bytes and in_free_offset with
// start high; the item is taken at the edge where start is high and busy low.
// An allocate item (in_req_type 0) rounds its size up to whole segments, takes
// the lowest free run of that length and returns its byte offset. A free item
// (in_req_type 1) releases the allocation whose head segment holds the offset.
// Result channel: every item gives exactly one result, shown on out_status and
// out_alloc_offset for one cycle while out_valid is high. The receiver cannot
// stall; the result register holds until the next result overwrites it, and a
// new item may be taken in the cycle its predecessor's result is shown.
// The single mark memory is touched one segment per cycle. An allocate scans
// from segment 0 to the end of the first run that fits, then writes the granted
// segments; with no fit the scan runs to the last segment. A free maps the offset
// to a segment by reciprocal multiply, checks its head mark and walks the freed
// allocation. A zero-size allocate is refused without touching the memory.
// After reset the mark memory is swept clear, one segment a cycle, over all
// SEGMENTS segments (2048 by default); busy stays high throughout.
module first_fit_segment_allocator #(
  parameter int SEGMENTS  = 2048,
  parameter int SEG_BYTES = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            in_req_type,
  input  wire logic [ffsa_pkg::SIZE_W-1:0]     in_size_bytes,
  input  wire logic [ffsa_pkg::OFFSET_W-1:0]   in_free_offset,
  output logic                                 out_valid,
  output logic      [ffsa_pkg::STATUS_W-1:0]   out_status,
  output logic      [ffsa_pkg::OFFSET_W-1:0]   out_alloc_offset
);
  import ffsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence the clear sweep, first-fit scan, mark pass, divide and free walk.
  ffsa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Hold the item, the mark memory, the run tracker, divider and result register.
  ffsa_dp #(
    .SEGMENTS  (SEGMENTS),
    .SEG_BYTES (SEG_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_req_type      (in_req_type),
    .in_size_bytes    (in_size_bytes),
    .in_free_offset   (in_free_offset),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_alloc_offset (out_alloc_offset)
  );

endmodule
`default_nettype wire

### dv/ffsa_req_pkg.sv
`default_nettype none
package ffsa_req_pkg;

  // Request kinds carried on in_req_type.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

endpackage
`default_nettype wire

### dv/ffsa_checker.sv
`default_nettype none
module ffsa_checker #(
  parameter int SEGMENTS  = 2048,
  parameter int SEG_BYTES = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire logic                          in_req_type,
  input  wire logic [ffsa_pkg::SIZE_W-1:0]   in_size_bytes,
  input  wire logic [ffsa_pkg::OFFSET_W-1:0] in_free_offset,
  input  wire logic                          out_valid,
  input  wire logic [ffsa_pkg::STATUS_W-1:0] out_status,
  input  wire logic [ffsa_pkg::OFFSET_W-1:0] out_alloc_offset,
  output int unsigned                        mismatches,
  output int unsigned                        pending
);
  import ffsa_pkg::*;
  import ffsa_req_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic                is_free;
    stat_t               status;
    logic [OFFSET_W-1:0] offset;
  } outcome_t;

  mark_t       seg_map [SEGMENTS];
  outcome_t    outcome_q [$];
  outcome_t    oldest;
  int unsigned fail_cnt = 0;

  // First fit: take the lowest run of free segments long enough for the size.
  function automatic outcome_t grant_run(logic [SIZE_W-1:0] size);
    outcome_t res;
    int       need;
    int       run;
    int       head;
    res.is_free = 1'b0;
    res.status  = ST_INVALID;
    res.offset  = '0;
    if (size == '0) return res;
    need = (int'(size) + SEG_BYTES - 1) / SEG_BYTES;
    res.status = ST_NOFIT;
    if (need > SEGMENTS) return res;
    run = 0;
    for (int i = 0; i < SEGMENTS; i++) begin
      run = (seg_map[i] == MARK_FREE) ? run + 1 : 0;
      if (run == need) begin
        head = i + 1 - need;
        seg_map[head] = MARK_HEAD;
        for (int j = head + 1; j <= i; j++) seg_map[j] = MARK_CONT;
        res.status = ST_OK;
        res.offset = OFFSET_W'(head * SEG_BYTES);
        return res;
      end
    end
    return res;
  endfunction

  // Release a head segment and the continuations directly above it.
  function automatic outcome_t release_run(logic [OFFSET_W-1:0] off);
    outcome_t res;
    int       seg;
    res.is_free = 1'b1;
    res.status  = ST_INVALID;
    res.offset  = '0;
    seg = int'(off) / SEG_BYTES;
    if (seg >= SEGMENTS || seg_map[seg] != MARK_HEAD) return res;
    seg_map[seg] = MARK_FREE;
    for (int j = seg + 1; j < SEGMENTS && seg_map[j] == MARK_CONT; j++)
      seg_map[j] = MARK_FREE;
    res.status = ST_OK;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (seg_map[i]) seg_map[i] = MARK_FREE;
      outcome_q.delete();
    end else begin
      // Compare before queuing: a new item may be taken on the result's edge.
      if (out_valid) begin
        if (outcome_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_LIMIT)
            $display("checker: unexpected result status %0d offset %0d at %0t",
                     out_status, out_alloc_offset, $time);
        end else begin
          oldest = outcome_q.pop_front();
          if (out_status !== oldest.status || out_alloc_offset !== oldest.offset) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_LIMIT)
              $display({"checker: %s mismatch at %0t: expected status %0d offset %0d,",
                        " got status %0d offset %0d"},
                       oldest.is_free ? "free" : "allocate", $time, oldest.status,
                       oldest.offset, out_status, out_alloc_offset);
          end
        end
      end
      if (start && !busy) begin
        if (in_req_type == REQ_FREE) outcome_q.push_back(release_run(in_free_offset));
        else outcome_q.push_back(grant_run(in_size_bytes));
      end
    end
    mismatches <= fail_cnt;
    pending    <= outcome_q.size();
  end

endmodule
`default_nettype wire

### dv/tb_top.sv
`default_nettype none
module tb_top;
  import ffsa_pkg::*;
  import ffsa_req_pkg::*;

  localparam int SEGMENTS     = 2048;
  localparam int SEG_BYTES    = 8;
  // Slowest item: a full-pool scan plus a full-pool mark write, plus the
  // sender's longest gap. The reset sweep also fits.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 268;
  // No idling in the last stretch of the random part.
  localparam int CALM_TAIL      = 40;
  // Cycles to watch for stray results after the last one.
  localparam int TAIL_CYCLES    = 64;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                start          = 1'b0;
  logic                in_req_type    = REQ_ALLOC;
  logic [SIZE_W-1:0]   in_size_bytes  = '0;
  logic [OFFSET_W-1:0] in_free_offset = '0;

  wire logic                busy;
  wire logic                out_valid;
  wire logic [STATUS_W-1:0] out_status;
  wire logic [OFFSET_W-1:0] out_alloc_offset;

  int unsigned mismatches;
  int unsigned pending;

  // Offsets of allocations granted and not yet freed, used to build frees.
  logic [OFFSET_W-1:0] live_q [$];
  // Kinds of accepted items whose results have not shown up yet.
  logic                kind_q [$];
  logic                res_kind;
  int unsigned         idle_cycles = 0;
  int unsigned         n_alloc     = 0;
  int unsigned         n_free      = 0;
  int unsigned         n_ok        = 0;
  int unsigned         n_nofit     = 0;
  int unsigned         n_invalid   = 0;

  first_fit_segment_allocator #(
    .SEGMENTS  (SEGMENTS),
    .SEG_BYTES (SEG_BYTES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_size_bytes    (in_size_bytes),
    .in_free_offset   (in_free_offset),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_alloc_offset (out_alloc_offset)
  );

  ffsa_checker #(
    .SEGMENTS  (SEGMENTS),
    .SEG_BYTES (SEG_BYTES)
  ) alloc_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_size_bytes    (in_size_bytes),
    .in_free_offset   (in_free_offset),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_alloc_offset (out_alloc_offset),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Track granted offsets on the falling edge, where every signal is settled
  // and shows what the next rising edge takes. Retire the shown result first,
  // since a new item can be taken on the same edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_valid && kind_q.size() != 0) begin
        res_kind = kind_q.pop_front();
        if (out_status == ST_OK) n_ok++;
        else if (out_status == ST_NOFIT) n_nofit++;
        else n_invalid++;
        if (res_kind == REQ_ALLOC && out_status == ST_OK) live_q.push_back(out_alloc_offset);
      end
      if (start && !busy) begin
        kind_q.push_back(in_req_type);
        if (in_req_type == REQ_FREE) n_free++;
        else n_alloc++;
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Present one item and hold it until the edge that takes it. Leave start
  // high afterwards; the next call or a pause decides what it does next.
  task automatic issue(input logic kind, input logic [SIZE_W-1:0] size,
                       input logic [OFFSET_W-1:0] off);
    start          <= 1'b1;
    in_req_type    <= kind;
    in_size_bytes  <= size;
    in_free_offset <= off;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop sending and wait until every outstanding result is back. Let one
  // edge pass first so the pending count covers the last accepted item.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int                  sel;
    int                  idx;
    logic [SIZE_W-1:0]   size;
    logic [OFFSET_W-1:0] off;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Unused fields carry random values the block must ignore.
    issue(REQ_FREE,  SIZE_W'($urandom), 14'd0);          // free of a free segment
    issue(REQ_ALLOC, 15'd0, OFFSET_W'($urandom));        // zero size
    issue(REQ_ALLOC, 15'd1, OFFSET_W'($urandom));        // one byte -> segment 0
    issue(REQ_ALLOC, 15'd8, OFFSET_W'($urandom));        // exactly one segment
    hold_off($urandom_range(1, 17));
    issue(REQ_ALLOC, 15'd9, OFFSET_W'($urandom));        // round up to two segments
    issue(REQ_ALLOC, 15'd16384, OFFSET_W'($urandom));    // whole pool, no room left
    issue(REQ_ALLOC, 15'h7FFF, OFFSET_W'($urandom));     // more than the pool holds
    issue(REQ_FREE,  SIZE_W'($urandom), 14'd24);         // continuation segment
    issue(REQ_FREE,  SIZE_W'($urandom), 14'd19);         // unaligned byte in a head
    issue(REQ_FREE,  SIZE_W'($urandom), 14'd19);         // same again, now free
    issue(REQ_ALLOC, 15'd16, OFFSET_W'($urandom));       // refill the hole first fit
    hold_off($urandom_range(1, 17));
    issue(REQ_FREE,  SIZE_W'($urandom), 14'd8);          // walk stops at next head
    issue(REQ_FREE,  SIZE_W'($urandom), 14'd0);
    issue(REQ_FREE,  SIZE_W'($urandom), 14'd16);
    issue(REQ_ALLOC, 15'd16384, OFFSET_W'($urandom));    // whole pool, empty
    issue(REQ_ALLOC, 15'd1, OFFSET_W'($urandom));        // pool full
    issue(REQ_FREE,  SIZE_W'($urandom), 14'h3FFF);       // top segment, continuation
    issue(REQ_FREE,  SIZE_W'($urandom), 14'd7);          // walk runs to top of pool
    issue(REQ_ALLOC, 15'd8, OFFSET_W'($urandom));
    issue(REQ_ALLOC, 15'd16376, OFFSET_W'($urandom));    // run ends at the last segment
    issue(REQ_FREE,  SIZE_W'($urandom), 14'd15);
    issue(REQ_FREE,  SIZE_W'($urandom), 14'h3FFF);       // top segment, free
    issue(REQ_FREE,  SIZE_W'($urandom), 14'd0);

    // Let the pool settle completely before the random part.
    wait_drained();

    // Random part: mostly allocations of small sizes and frees of granted
    // runs, with some broken frees and out-of-range sizes mixed in.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n < RANDOM_ITEMS - CALM_TAIL) begin
        if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 17));
        if ($urandom_range(0, 59) == 0) wait_drained();
      end
      sel = $urandom_range(0, 99);
      // Lean toward frees once many runs are live, to keep scans short.
      if (sel < ((live_q.size() > 24) ? 70 : 35)) begin
        sel = $urandom_range(0, 99);
        if (live_q.size() != 0 && sel < 75) begin
          idx = $urandom_range(0, live_q.size() - 1);
          off = live_q[idx] + OFFSET_W'($urandom_range(0, SEG_BYTES - 1));
          live_q.delete(idx);
        end else if (live_q.size() != 0 && sel < 88) begin
          // Aim past a head: continuation, another head or a free segment.
          off = live_q[$urandom_range(0, live_q.size() - 1)]
                + OFFSET_W'(SEG_BYTES * $urandom_range(1, 4));
        end else begin
          off = OFFSET_W'($urandom_range(0, 16383));
        end
        issue(REQ_FREE, SIZE_W'($urandom), off);
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 65) size = SIZE_W'($urandom_range(1, 64));
        else if (sel < 85) size = SIZE_W'($urandom_range(65, 512));
        else if (sel < 92) size = SIZE_W'($urandom_range(513, 16384));
        else if (sel < 96) size = '0;
        else size = SIZE_W'($urandom_range(0, 32767));
        issue(REQ_ALLOC, size, OFFSET_W'($urandom));
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("summary: %0d requests (%0d allocate, %0d free), first-fit holes, unaligned,",
             n_alloc + n_free, n_alloc, n_free);
    $display("summary: continuation and oversize cases; %0d ok, %0d no fit, %0d invalid",
             n_ok, n_nofit, n_invalid);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
hdl/ffsa_pkg.sv
hdl/ffsa_ram.sv
hdl/ffsa_ctrl.sv
hdl/ffsa_dp.sv
hdl/first_fit_segment_allocator.sv
dv/ffsa_req_pkg.sv
dv/ffsa_checker.sv
dv/tb_top.sv
